// ===== sv/cgr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cgr_pkg
// Shared constants for the gray component replacement datapath.
// ============================================================================
package cgr_pkg;

    // Default channel width; 2^CHANNEL_BITS - 1 stands for full ink
    localparam int unsigned CHANNEL_BITS_DEF = 16;

    // Configuration field widths
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned LIMIT_W    = 9;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 9;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PULLOUT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INK_LIMIT = CFG_IDX_W'(1);

    // Percent scale and reset values
    localparam logic [PCT_W-1:0]   PCT_MAX       = PCT_W'(100);
    localparam logic [PCT_W-1:0]   PULLOUT_RST   = PCT_W'(100);
    localparam logic [LIMIT_W-1:0] INK_LIMIT_RST = LIMIT_W'(250);

    // ceil(log2(100)): extra shift for the exact reciprocal divide by 100
    localparam int unsigned PCT_LOG2 = 7;

endpackage

// ===== sv/cgr_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cgr_front
// Pullout, divisor, black channel and initial divider remainders (4 stages).
// ============================================================================
module cgr_front import cgr_pkg::*; #(
    parameter int unsigned W = CHANNEL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [W-1:0]         i_cyan,
    input  logic [W-1:0]         i_magenta,
    input  logic [W-1:0]         i_yellow,
    input  logic [W-1:0]         i_black,
    input  logic [W-1:0]         i_alpha,
    input  logic                 i_last,
    input  logic [PCT_W-1:0]     i_amount,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [W-1:0]         o_div,
    output logic                 o_zero,
    output logic [2:0][W-1:0]    o_rem,
    output logic [2:0][W-1:0]    o_shf,
    output logic [W-1:0]         o_black,
    output logic [W-1:0]         o_alpha,
    output logic                 o_last
);

    localparam int unsigned PW     = W + PCT_W;
    localparam int unsigned RS     = PW + PCT_LOG2;
    localparam int unsigned PROD_W = 2 * PW + 1;
    localparam logic [63:0] RECIP_WIDE = ((64'd1 << RS) + 64'd99) / 64'd100;
    localparam logic [PW:0] RECIP = RECIP_WIDE[PW:0];

    logic [3:0] r_v;
    logic [4:0] w_rdy;

    // stage 1
    logic [2:0][W-1:0] r1_x;
    logic [W-1:0]      r1_k, r1_a;
    logic              r1_last;
    logic [PW-1:0]     r1_prod;
    // stage 2
    logic [2:0][W-1:0] r2_x;
    logic [W-1:0]      r2_k, r2_a;
    logic              r2_last;
    logic [PROD_W-1:0] r2_scaled;
    // stage 3
    logic [2:0][W-1:0] r3_d;
    logic [W-1:0]      r3_div, r3_a;
    logic              r3_zero, r3_last;
    logic [2*W-1:0]    r3_kprod;
    // stage 4
    logic [2:0][W-1:0] r4_rem, r4_shf;
    logic [W-1:0]      r4_div, r4_k, r4_a;
    logic              r4_zero, r4_last;

    logic [W-1:0]      w_min, w_p, w_kn, w_pn, w_kq;
    logic [PW-1:0]     w_prod;
    logic [PROD_W-1:0] w_scaled;
    logic [2*W-1:0]    w_kprod;
    logic [2*W:0]      w_ksum;
    logic [2:0][2*W-1:0] w_num;

    always_comb begin
        w_rdy[4] = i_ready;
        for (int s = 3; s >= 0; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    end
    assign o_ready = w_rdy[0];

    // smallest of C, M and Y scaled by the pullout share
    always_comb begin
        w_min = i_cyan;
        if (i_magenta < w_min) begin
            w_min = i_magenta;
        end
        if (i_yellow < w_min) begin
            w_min = i_yellow;
        end
    end
    assign w_prod   = {{PCT_W{1'b0}}, w_min} * {{W{1'b0}}, i_amount};
    assign w_scaled = PROD_W'(r1_prod) * PROD_W'(RECIP);
    assign w_p      = r2_scaled[RS +: W];
    assign w_kn     = ~r2_k;
    assign w_pn     = ~w_p;
    assign w_kprod  = (2*W)'(w_kn) * (2*W)'(w_pn);

    // floor(x / FULL) for x <= FULL^2
    assign w_ksum = {1'b0, r3_kprod} + (2*W+1)'(r3_kprod[2*W-1:W]) + (2*W+1)'(1);
    assign w_kq   = w_ksum[2*W-1:W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {r3_d[i], {W{1'b0}}} - {{W{1'b0}}, r3_d[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_x    <= {i_yellow, i_magenta, i_cyan};
            r1_k    <= i_black;
            r1_a    <= i_alpha;
            r1_last <= i_last;
            r1_prod <= w_prod;
        end
        if (w_rdy[1]) begin
            r2_x      <= r1_x;
            r2_k      <= r1_k;
            r2_a      <= r1_a;
            r2_last   <= r1_last;
            r2_scaled <= w_scaled;
        end
        if (w_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_d[i] <= r2_x[i] - w_p;
            end
            r3_div   <= w_pn;
            r3_zero  <= &w_p;
            r3_kprod <= w_kprod;
            r3_a     <= r2_a;
            r3_last  <= r2_last;
        end
        if (w_rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_rem[i] <= w_num[i][2*W-1:W];
                r4_shf[i] <= w_num[i][W-1:0];
            end
            r4_div  <= r3_div;
            r4_zero <= r3_zero;
            r4_k    <= ~w_kq;
            r4_a    <= r3_a;
            r4_last <= r3_last;
        end
    end

    assign o_valid = r_v[3];
    assign o_div   = r4_div;
    assign o_zero  = r4_zero;
    assign o_rem   = r4_rem;
    assign o_shf   = r4_shf;
    assign o_black = r4_k;
    assign o_alpha = r4_a;
    assign o_last  = r4_last;

endmodule

// ===== sv/cgr_div_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cgr_div_cell
// One restoring-division step: one quotient bit for each of C, M and Y.
// ============================================================================
module cgr_div_cell import cgr_pkg::*; #(
    parameter int unsigned W = CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [W-1:0]      i_div,
    input  logic              i_zero,
    input  logic [2:0][W-1:0] i_rem,
    input  logic [2:0][W-1:0] i_shf,
    input  logic [W-1:0]      i_black,
    input  logic [W-1:0]      i_alpha,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [W-1:0]      o_div,
    output logic              o_zero,
    output logic [2:0][W-1:0] o_rem,
    output logic [2:0][W-1:0] o_shf,
    output logic [W-1:0]      o_black,
    output logic [W-1:0]      o_alpha,
    output logic              o_last
);

    logic              r_v;
    logic              w_rdy;
    logic [2:0][W-1:0] r_rem, r_shf, n_rem, n_shf;
    logic [W-1:0]      r_div, r_k, r_a;
    logic              r_zero, r_last;
    logic [W:0]        w_trial, w_diff;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;

    // shift in the next dividend bit, subtract where it fits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_trial  = {i_rem[i], i_shf[i][W-1]};
            w_diff   = w_trial - {1'b0, i_div};
            n_rem[i] = (w_trial >= {1'b0, i_div}) ? w_diff[W-1:0] : w_trial[W-1:0];
            n_shf[i] = {i_shf[i][W-2:0], (w_trial >= {1'b0, i_div})};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_rem  <= n_rem;
            r_shf  <= n_shf;
            r_div  <= i_div;
            r_zero <= i_zero;
            r_k    <= i_black;
            r_a    <= i_alpha;
            r_last <= i_last;
        end
    end

    assign o_valid = r_v;
    assign o_div   = r_div;
    assign o_zero  = r_zero;
    assign o_rem   = r_rem;
    assign o_shf   = r_shf;
    assign o_black = r_k;
    assign o_alpha = r_a;
    assign o_last  = r_last;

endmodule

// ===== sv/cgr_ink_check.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cgr_ink_check
// Total ink against the limit, magenta substitution and output register.
// ============================================================================
module cgr_ink_check import cgr_pkg::*; #(
    parameter int unsigned W = CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_zero,
    input  logic [2:0][W-1:0] i_quot,
    input  logic [W-1:0]      i_black,
    input  logic [W-1:0]      i_alpha,
    input  logic              i_last,
    input  logic [W+LIMIT_W-1:0] i_ink_cap,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [W-1:0]      o_cyan,
    output logic [W-1:0]      o_magenta,
    output logic [W-1:0]      o_yellow,
    output logic [W-1:0]      o_black,
    output logic [W-1:0]      o_alpha,
    output logic              o_hit,
    output logic              o_last
);

    localparam int unsigned SW = W + LIMIT_W;

    logic [2:0] r_v;
    logic [3:0] w_rdy;

    logic [2:0][W-1:0] r1_x, r2_x;
    logic [W-1:0]      r1_k, r1_a, r2_k, r2_a;
    logic              r1_last, r2_last;
    logic [W+1:0]      r1_sum;
    logic [SW-1:0]     r2_scaled;

    logic [W-1:0] r3_c, r3_m, r3_y, r3_k, r3_a;
    logic         r3_hit, r3_last;

    logic [2:0][W-1:0] w_x;
    logic [W+1:0]      w_sum;
    logic [SW-1:0]     w_scaled;
    logic              w_hit;

    always_comb begin
        w_rdy[3] = i_ready;
        for (int s = 2; s >= 0; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    end
    assign o_ready = w_rdy[0];

    // full gray pullout: C, M and Y drop to zero
    assign w_x   = i_zero ? '0 : i_quot;
    assign w_sum = (W+2)'(w_x[0]) + (W+2)'(w_x[1]) + (W+2)'(w_x[2]) + (W+2)'(i_black);
    // times 100 as 64 + 32 + 4
    assign w_scaled = SW'({r1_sum, 6'd0}) + SW'({r1_sum, 5'd0}) + SW'({r1_sum, 2'd0});
    assign w_hit    = r2_scaled > i_ink_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_x    <= w_x;
            r1_k    <= i_black;
            r1_a    <= i_alpha;
            r1_last <= i_last;
            r1_sum  <= w_sum;
        end
        if (w_rdy[1]) begin
            r2_x      <= r1_x;
            r2_k      <= r1_k;
            r2_a      <= r1_a;
            r2_last   <= r1_last;
            r2_scaled <= w_scaled;
        end
        if (w_rdy[2]) begin
            r3_c    <= w_hit ? '0 : r2_x[0];
            r3_m    <= w_hit ? '1 : r2_x[1];
            r3_y    <= w_hit ? '0 : r2_x[2];
            r3_k    <= w_hit ? '0 : r2_k;
            r3_a    <= r2_a;
            r3_hit  <= w_hit;
            r3_last <= r2_last;
        end
    end

    assign o_valid   = r_v[2];
    assign o_cyan    = r3_c;
    assign o_magenta = r3_m;
    assign o_yellow  = r3_y;
    assign o_black   = r3_k;
    assign o_alpha   = r3_a;
    assign o_hit     = r3_hit;
    assign o_last    = r3_last;

endmodule

// ===== sv/cmyk_gray_component_replace.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cmyk_gray_component_replace
// Gray component replacement on a CMYKA pixel stream, one pixel per clock while the output is not stalled.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one CMYKA pixel per beat,
//   with an end-of-run mark. Output channel (o_out_valid / i_out_ready)
//   returns one pixel per beat in the same order, with alpha and the mark
//   copied and a flag that shows the ink limit was exceeded.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes register 0
//   (pullout percent, saturated at 100) or 1 (ink limit percent); it is
//   always ready. Write it only while no pixel is in flight.
//   The path runs through four front stages, one divider cell per quotient
//   bit and three ink-check stages ending in the output register.
//   Throughput is one pixel per clock while the receiver keeps taking beats;
//   every stage is a register slice, so a beat moves on whenever the stage
//   ahead is empty or moving.
//   When the receiver stalls, held beats pile up stage by stage and the input
//   keeps accepting until the whole chain is full.
//   Reset empties every stage and returns pullout to 100 % and the ink limit
//   to 250 %; no clearing pass is needed.
// ============================================================================
module cmyk_gray_component_replace import cgr_pkg::*; #(
    parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // pixel in
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CHANNEL_BITS-1:0] i_in_cyan,
    input  logic [CHANNEL_BITS-1:0] i_in_magenta,
    input  logic [CHANNEL_BITS-1:0] i_in_yellow,
    input  logic [CHANNEL_BITS-1:0] i_in_black,
    input  logic [CHANNEL_BITS-1:0] i_in_alpha,
    input  logic                    i_in_last,
    // pixel out
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CHANNEL_BITS-1:0] o_out_cyan,
    output logic [CHANNEL_BITS-1:0] o_out_magenta,
    output logic [CHANNEL_BITS-1:0] o_out_yellow,
    output logic [CHANNEL_BITS-1:0] o_out_black,
    output logic [CHANNEL_BITS-1:0] o_out_alpha,
    output logic                    o_ink_limit_hit,
    output logic                    o_out_last,
    // register writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned W     = CHANNEL_BITS;
    localparam int unsigned CAP_W = W + LIMIT_W;
    // 250 % of full ink, the limit after reset
    localparam logic [CAP_W-1:0] INK_CAP_RST =
        (CAP_W'(INK_LIMIT_RST) << W) - CAP_W'(INK_LIMIT_RST);

    logic [PCT_W-1:0] r_pullout;
    logic [CAP_W-1:0] r_ink_cap;
    logic [PCT_W-1:0] w_amount;
    logic [CAP_W-1:0] w_cap_wr;

    // --------------------------------------------------------------------
    // Configuration: hold the pullout share and the ink limit, the latter
    // already scaled to limit * FULL so the check needs one compare.
    // --------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign w_cap_wr = (CAP_W'(i_cfg_data[LIMIT_W-1:0]) << W)
                    - CAP_W'(i_cfg_data[LIMIT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pullout <= PULLOUT_RST;
            r_ink_cap <= INK_CAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PULLOUT:   r_pullout <= i_cfg_data[PCT_W-1:0];
                CFG_INK_LIMIT: r_ink_cap <= w_cap_wr;
                default: ;
            endcase
        end
    end

    // saturate the share at 100 %
    assign w_amount = (r_pullout > PCT_MAX) ? PCT_MAX : r_pullout;

    // --------------------------------------------------------------------
    // Chain links: index j feeds divider cell j, index W feeds the check.
    // --------------------------------------------------------------------
    logic              w_v     [0:W];
    logic              w_rdy   [0:W];
    logic [W-1:0]      w_div   [0:W];
    logic              w_zero  [0:W];
    logic [2:0][W-1:0] w_rem   [0:W];
    logic [2:0][W-1:0] w_shf   [0:W];
    logic [W-1:0]      w_black [0:W];
    logic [W-1:0]      w_alpha [0:W];
    logic              w_last  [0:W];

    cgr_front #(
        .W (W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_cyan    (i_in_cyan),
        .i_magenta (i_in_magenta),
        .i_yellow  (i_in_yellow),
        .i_black   (i_in_black),
        .i_alpha   (i_in_alpha),
        .i_last    (i_in_last),
        .i_amount  (w_amount),
        .o_valid   (w_v[0]),
        .i_ready   (w_rdy[0]),
        .o_div     (w_div[0]),
        .o_zero    (w_zero[0]),
        .o_rem     (w_rem[0]),
        .o_shf     (w_shf[0]),
        .o_black   (w_black[0]),
        .o_alpha   (w_alpha[0]),
        .o_last    (w_last[0])
    );

    // one cell per quotient bit, most significant first
    for (genvar j = 0; j < W; j++) begin : g_cell
        cgr_div_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[j]),
            .o_ready (w_rdy[j]),
            .i_div   (w_div[j]),
            .i_zero  (w_zero[j]),
            .i_rem   (w_rem[j]),
            .i_shf   (w_shf[j]),
            .i_black (w_black[j]),
            .i_alpha (w_alpha[j]),
            .i_last  (w_last[j]),
            .o_valid (w_v[j+1]),
            .i_ready (w_rdy[j+1]),
            .o_div   (w_div[j+1]),
            .o_zero  (w_zero[j+1]),
            .o_rem   (w_rem[j+1]),
            .o_shf   (w_shf[j+1]),
            .o_black (w_black[j+1]),
            .o_alpha (w_alpha[j+1]),
            .o_last  (w_last[j+1])
        );
    end

    // after the last cell the shift registers hold the quotients
    cgr_ink_check #(
        .W (W)
    ) u_ink (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_v[W]),
        .o_ready   (w_rdy[W]),
        .i_zero    (w_zero[W]),
        .i_quot    (w_shf[W]),
        .i_black   (w_black[W]),
        .i_alpha   (w_alpha[W]),
        .i_last    (w_last[W]),
        .i_ink_cap (r_ink_cap),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_cyan    (o_out_cyan),
        .o_magenta (o_out_magenta),
        .o_yellow  (o_out_yellow),
        .o_black   (o_out_black),
        .o_alpha   (o_out_alpha),
        .o_hit     (o_ink_limit_hit),
        .o_last    (o_out_last)
    );

endmodule

// ===== sv/cgr_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cgr_checker
// Port-level checks for the gray component replacement block.
// ============================================================================
module cgr_checker import cgr_pkg::*; #(
    parameter int unsigned W = CHANNEL_BITS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_in_ready,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] o_out_cyan,
    input logic [W-1:0] o_out_magenta,
    input logic [W-1:0] o_out_yellow,
    input logic [W-1:0] o_out_black,
    input logic         o_ink_limit_hit
);

    // a held result beat stays valid, with cyan, magenta and black unchanged, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_cyan)
            && $stable(o_out_magenta) && $stable(o_out_black))
        else $error("result beat changed while stalled");

    // a flagged pixel is pure magenta
    a_hit_magenta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ink_limit_hit |-> o_out_cyan == '0
            && o_out_magenta == '1 && o_out_yellow == '0 && o_out_black == '0)
        else $error("ink warning without magenta substitution");

    // reset empties the chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat after reset");

    // a free output stage lets the whole chain move
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled with a free output");

endmodule

bind cmyk_gray_component_replace cgr_checker #(
    .W (CHANNEL_BITS)
) u_cgr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_cyan      (o_out_cyan),
    .o_out_magenta   (o_out_magenta),
    .o_out_yellow    (o_out_yellow),
    .o_out_black     (o_out_black),
    .o_ink_limit_hit (o_ink_limit_hit)
);
